// ===== rtl/core/mcct_pkg.sv =====
package mcct_pkg;

  localparam int unsigned TimerCountDefault = 8;
  localparam int unsigned MsW = 16;
  localparam int unsigned MinW = 8;
  localparam int unsigned NumW = 4;
  localparam int unsigned AnsW = 4;

  localparam logic [MsW:0] MsPerMinute = 17'd60000;

  typedef enum logic [2:0] {
    ModeTick     = 3'd0,
    ModeArmMain  = 3'd1,
    ModeArmMisc  = 3'd2,
    ModeOvertime = 3'd3,
    ModePollMain = 3'd4,
    ModePollMisc = 3'd5,
    ModeTake     = 3'd6,
    ModeIdle     = 3'd7
  } mode_e;

  typedef struct packed {
    logic [AnsW-1:0] answer;
    logic [MsW-1:0]  clock_ms;
    logic [MinW-1:0] clock_minutes;
    logic            error;
  } result_t;

  typedef struct packed {
    mode_e           mode;
    logic [NumW-1:0] timer_number;
    logic [MsW-1:0]  delay_ms;
  } item_t;

endpackage

// ===== rtl/core/minute_clock_countdown_timers.sv =====
// Minute clock with one main and TIMER_COUNT numbered countdown timers.
// Input channel: mode_i, timer_number_i and delay_ms_i under in_valid_i and
// in_ready_o. Output channel: answer_o, clock_ms_o, clock_minutes_o and
// error_o under out_valid_o and out_ready_i. Every input beat yields exactly
// one output beat, in order.
// An accepted beat lands in an input register; once the result register is free,
// the block updates its clock and timer state and loads the result register.
// One beat is taken in every cycle while the receiver keeps out_ready_i high;
// the throughput is set by the single pass through the timer comparators
// between these two registers.
// When the receiver stalls, the result register holds its beat and the input
// register holds one more; in_ready_o falls only when both are full.
// Reset clears the clock, all goals, flags and both valid bits, so the main
// timer reads as expired and no misc timer is armed.
module minute_clock_countdown_timers
  import mcct_pkg::*;
#(
  parameter int unsigned TIMER_COUNT = TimerCountDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2:0]      mode_i,
  input  logic [NumW-1:0] timer_number_i,
  input  logic [MsW-1:0]  delay_ms_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [AnsW-1:0] answer_o,
  output logic [MsW-1:0]  clock_ms_o,
  output logic [MinW-1:0] clock_minutes_o,
  output logic            error_o
);

  item_t   item_q;
  logic    item_valid_q;
  result_t res_q, res_d;
  logic    res_valid_q;
  logic    res_free, advance;

  logic [MsW-1:0]  ms_q, ms_d;
  logic [MinW-1:0] min_q, min_d;
  logic [MsW-1:0]  main_goal_q, main_goal_d;
  logic            main_roll_q, main_roll_d;
  logic            main_run_q, main_run_d;
  logic            overtime_q, overtime_d;
  logic            notified_q, notified_d;

  logic [MsW-1:0]         misc_goal_q [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] misc_roll_q, misc_roll_d;
  logic [TIMER_COUNT-1:0] misc_run_q, misc_run_d;
  logic [TIMER_COUNT-1:0] misc_armed_q, misc_armed_d;
  logic [TIMER_COUNT-1:0] misc_hit, expired, first_oh;
  logic [AnsW-1:0]        first_num;
  logic                   any_expired, arm_misc_wr;

  logic [MsW:0]   now, goal_sum;
  logic [MsW-1:0] new_goal;
  logic           new_roll;

  assign res_free   = !res_valid_q || out_ready_i;
  assign advance    = item_valid_q && res_free;
  assign in_ready_o = !item_valid_q || res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      if (res_free) begin
        res_valid_q <= item_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.mode         <= mode_e'(mode_i);
      item_q.timer_number <= timer_number_i;
      item_q.delay_ms     <= delay_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  // The goal sum is kept at 17 bits so that it never wraps.
  always_comb begin
    goal_sum = {1'b0, ms_q} + {1'b0, item_q.delay_ms};
    now      = {1'b0, ms_q} + 17'd1;
    if (goal_sum > MsPerMinute) begin
      new_goal = MsW'(goal_sum - MsPerMinute);
      new_roll = 1'b1;
    end else begin
      new_goal = goal_sum[MsW-1:0];
      new_roll = 1'b0;
    end
  end

  always_comb begin
    for (int t = 0; t < TIMER_COUNT; t++) begin
      misc_hit[t] = ({2'b00, item_q.timer_number} == 6'(t + 1));
      expired[t]  = misc_armed_q[t] && !misc_run_q[t];
    end
    any_expired = |expired;
    first_oh    = '0;
    first_num   = '0;
    for (int t = TIMER_COUNT - 1; t >= 0; t--) begin
      if (expired[t]) begin
        first_oh      = '0;
        first_oh[t]   = 1'b1;
        first_num     = AnsW'(t + 1);
      end
    end
  end

  always_comb begin
    ms_d         = ms_q;
    min_d        = min_q;
    main_goal_d  = main_goal_q;
    main_roll_d  = main_roll_q;
    main_run_d   = main_run_q;
    overtime_d   = overtime_q;
    notified_d   = notified_q;
    misc_roll_d  = misc_roll_q;
    misc_run_d   = misc_run_q;
    misc_armed_d = misc_armed_q;
    arm_misc_wr  = 1'b0;
    res_d.answer = '0;
    res_d.error  = 1'b0;

    unique case (item_q.mode)
      ModeTick: begin
        if (main_run_q && !main_roll_q && now >= {1'b0, main_goal_q}) begin
          main_run_d = 1'b0;
        end
        for (int t = 0; t < TIMER_COUNT; t++) begin
          if (misc_run_q[t] && !misc_roll_q[t] && now >= {1'b0, misc_goal_q[t]}) begin
            misc_run_d[t] = 1'b0;
          end
        end
        if (now >= MsPerMinute) begin
          ms_d        = '0;
          min_d       = min_q + MinW'(1);
          main_roll_d = 1'b0;
          misc_roll_d = '0;
        end else begin
          ms_d = now[MsW-1:0];
        end
      end
      ModeArmMain: begin
        main_goal_d = new_goal;
        main_roll_d = new_roll;
        main_run_d  = 1'b1;
      end
      ModeArmMisc: begin
        if (item_q.timer_number == '0) begin
          res_d.error = 1'b1;
        end else begin
          arm_misc_wr = 1'b1;
          for (int t = 0; t < TIMER_COUNT; t++) begin
            if (misc_hit[t]) begin
              misc_roll_d[t]  = new_roll;
              misc_run_d[t]   = 1'b1;
              misc_armed_d[t] = 1'b1;
            end
          end
        end
      end
      ModeOvertime: begin
        overtime_d = 1'b1;
      end
      ModePollMain: begin
        if (!main_run_q) begin
          if (overtime_q) begin
            overtime_d = 1'b0;
          end else begin
            res_d.answer = AnsW'(1);
          end
        end
      end
      ModePollMisc: begin
        if (any_expired) begin
          notified_d   = 1'b1;
          res_d.answer = AnsW'(1);
        end
      end
      ModeTake: begin
        if (!notified_q) begin
          res_d.error = 1'b1;
        end else if (any_expired) begin
          misc_armed_d = misc_armed_q & ~first_oh;
          notified_d   = 1'b0;
          res_d.answer = first_num;
        end
      end
      default: begin
      end
    endcase

    res_d.clock_ms      = ms_d;
    res_d.clock_minutes = min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q         <= '0;
      min_q        <= '0;
      main_goal_q  <= '0;
      main_roll_q  <= 1'b0;
      main_run_q   <= 1'b0;
      overtime_q   <= 1'b0;
      notified_q   <= 1'b0;
      misc_roll_q  <= '0;
      misc_run_q   <= '0;
      misc_armed_q <= '0;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        misc_goal_q[t] <= '0;
      end
    end else if (advance) begin
      ms_q         <= ms_d;
      min_q        <= min_d;
      main_goal_q  <= main_goal_d;
      main_roll_q  <= main_roll_d;
      main_run_q   <= main_run_d;
      overtime_q   <= overtime_d;
      notified_q   <= notified_d;
      misc_roll_q  <= misc_roll_d;
      misc_run_q   <= misc_run_d;
      misc_armed_q <= misc_armed_d;
      for (int t = 0; t < TIMER_COUNT; t++) begin
        if (arm_misc_wr && misc_hit[t]) begin
          misc_goal_q[t] <= new_goal;
        end
      end
    end
  end

  assign out_valid_o     = res_valid_q;
  assign answer_o        = res_q.answer;
  assign clock_ms_o      = res_q.clock_ms;
  assign clock_minutes_o = res_q.clock_minutes;
  assign error_o         = res_q.error;

`ifndef NO_ASSERTIONS
  a_ms_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, ms_q} < MsPerMinute)
    else $error("millisecond counter out of range");

  a_error_no_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> answer_o == '0)
    else $error("error beat carries an answer");

  a_tick_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.mode == ModeTick && now < MsPerMinute
    |=> ms_q == $past(ms_q) + MsW'(1))
    else $error("tick did not advance the clock");

  a_minute_only_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && min_q != min_d |-> ms_d == '0)
    else $error("minute changed without a wrap");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

import mcct_pkg::*;

class timer_board;
  bit [MsW-1:0]  ms;
  bit [MinW-1:0] minutes;
  bit [MsW-1:0]  main_goal;
  bit            main_roll;
  bit            main_run;
  bit            overtime;
  bit [MsW-1:0]  goal [TimerCountDefault];
  bit            roll [TimerCountDefault];
  bit            run [TimerCountDefault];
  bit            armed [TimerCountDefault];
  bit            notified;
  result_t       awaited [$];
  int            fails;

  function new();
    fails = 0;
  endfunction

  function void arm(input bit [MsW-1:0] delay, output bit [MsW-1:0] g, output bit r);
    bit [MsW:0] sum;
    sum = {1'b0, ms} + {1'b0, delay};
    if (sum > MsPerMinute) begin
      sum = sum - MsPerMinute;
      r = 1'b1;
    end else begin
      r = 1'b0;
    end
    g = sum[MsW-1:0];
  endfunction

  function int first_due();
    for (int t = 0; t < TimerCountDefault; t++) begin
      if (armed[t] && !run[t]) return t;
    end
    return -1;
  endfunction

  function void advance_clock();
    bit [MsW:0] now;
    now = {1'b0, ms} + 17'd1;
    if (main_run && !main_roll && now >= {1'b0, main_goal}) main_run = 1'b0;
    for (int t = 0; t < TimerCountDefault; t++) begin
      if (run[t] && !roll[t] && now >= {1'b0, goal[t]}) run[t] = 1'b0;
    end
    if (now >= MsPerMinute) begin
      now = '0;
      minutes = minutes + 8'd1;
      main_roll = 1'b0;
      for (int t = 0; t < TimerCountDefault; t++) roll[t] = 1'b0;
    end
    ms = now[MsW-1:0];
  endfunction

  function void log_item(mode_e m, bit [NumW-1:0] num, bit [MsW-1:0] delay);
    result_t res;
    int idx;
    res = '0;
    case (m)
      ModeTick: advance_clock();
      ModeArmMain: begin
        arm(delay, main_goal, main_roll);
        main_run = 1'b1;
      end
      ModeArmMisc: begin
        if (num == 0) begin
          res.error = 1'b1;
        end else if (num <= TimerCountDefault) begin
          idx = num - 1;
          arm(delay, goal[idx], roll[idx]);
          armed[idx] = 1'b1;
          run[idx] = 1'b1;
        end
      end
      ModeOvertime: overtime = 1'b1;
      ModePollMain: begin
        if (!main_run) begin
          if (overtime) overtime = 1'b0;
          else res.answer = AnsW'(1);
        end
      end
      ModePollMisc: begin
        if (first_due() >= 0) begin
          notified = 1'b1;
          res.answer = AnsW'(1);
        end
      end
      ModeTake: begin
        if (!notified) begin
          res.error = 1'b1;
        end else begin
          idx = first_due();
          if (idx >= 0) begin
            armed[idx] = 1'b0;
            notified = 1'b0;
            res.answer = AnsW'(idx + 1);
          end
        end
      end
      default: ;
    endcase
    res.clock_ms = ms;
    res.clock_minutes = minutes;
    awaited.push_back(res);
  endfunction

  function void check_beat(logic [AnsW-1:0] answer, logic [MsW-1:0] clock_ms,
                           logic [MinW-1:0] clock_minutes, logic error);
    result_t want;
    if (awaited.size() == 0) begin
      $error("result beat arrived with nothing expected");
      fails++;
      return;
    end
    want = awaited.pop_front();
    if (answer !== want.answer) begin
      $error("answer: expected %0d, got %0d", want.answer, answer);
      fails++;
    end
    if (clock_ms !== want.clock_ms) begin
      $error("clock_ms: expected %0d, got %0d", want.clock_ms, clock_ms);
      fails++;
    end
    if (clock_minutes !== want.clock_minutes) begin
      $error("clock_minutes: expected %0d, got %0d", want.clock_minutes, clock_minutes);
      fails++;
    end
    if (error !== want.error) begin
      $error("error: expected %0d, got %0d", want.error, error);
      fails++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_top;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [2:0]      mode = ModeIdle;
  logic [NumW-1:0] timer_number = '0;
  logic [MsW-1:0]  delay_ms = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [AnsW-1:0] answer;
  logic [MsW-1:0]  clock_ms;
  logic [MinW-1:0] clock_minutes;
  logic            error;

  bit fast_lane = 1'b0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  timer_board board;

  minute_clock_countdown_timers DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .timer_number_i (timer_number),
    .delay_ms_i     (delay_ms),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .answer_o       (answer),
    .clock_ms_o     (clock_ms),
    .clock_minutes_o(clock_minutes),
    .error_o        (error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic mode_e pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ModeTick;
    if (r < 43) return ModeArmMain;
    if (r < 58) return ModeArmMisc;
    if (r < 63) return ModeOvertime;
    if (r < 73) return ModePollMain;
    if (r < 85) return ModePollMisc;
    if (r < 97) return ModeTake;
    return ModeIdle;
  endfunction

  function automatic bit [NumW-1:0] pick_number();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return NumW'($urandom_range(1, TimerCountDefault));
    if (r < 88) return '0;
    return NumW'($urandom_range(TimerCountDefault + 1, 15));
  endfunction

  function automatic bit [MsW-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return MsW'($urandom_range(0, 40));
    if (r < 75) return MsW'($urandom_range(0, 300));
    if (r < 90) return MsW'($urandom_range(0, 65535));
    return MsW'($urandom_range(59990, 65535));
  endfunction

  task automatic send(input mode_e m, input bit [NumW-1:0] num, input bit [MsW-1:0] delay);
    int gap;
    gap = (fast_lane || tx_steady) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    timer_number <= num;
    delay_ms <= delay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.log_item(m, num, delay);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      send(pick_mode(), pick_number(), pick_delay());
    end
  endtask

  initial begin : receiver
    int gap;
    int beats;
    beats = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (beats % 50 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      if (fast_lane) gap = 0;
      else if (beats == 200) gap = 120;
      else if (rx_steady) gap = 0;
      else gap = $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_beat(answer, clock_ms, clock_minutes, error);
      beats++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    board = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(ModePollMain, 0, 0);
    send(ModeTake, 0, 0);
    send(ModePollMisc, 0, 0);
    send(ModeArmMisc, 0, 100);
    send(ModeArmMisc, 9, 0);
    send(ModeArmMisc, 15, 16'hFFFF);
    send(ModeIdle, 15, 16'hFFFF);
    send(ModeArmMain, 0, 0);
    send(ModeOvertime, 0, 0);
    send(ModePollMain, 0, 0);
    send(ModeTick, 0, 0);
    send(ModePollMain, 0, 0);
    send(ModePollMain, 0, 0);
    send(ModeArmMisc, 1, 0);
    send(ModeArmMisc, 8, 2);
    send(ModeArmMisc, 2, 16'hFFFF);
    send(ModeTake, 0, 0);
    send(ModeTick, 0, 0);
    send(ModePollMisc, 0, 0);
    send(ModePollMisc, 0, 0);
    send(ModeArmMisc, 1, 5);
    send(ModeTake, 0, 0);
    send(ModeTick, 0, 0);
    send(ModeTake, 0, 0);
    send(ModeArmMain, 0, 59999);

    send_random(700);

    // Run a burst of ticks with no gaps on either side.
    tx_steady = 1'b0;
    send(ModeArmMisc, 3, 30000);
    send(ModeArmMain, 0, 45000);
    fast_lane = 1'b1;
    for (int n = 0; n < 200; n++) send(ModeTick, pick_number(), pick_delay());
    fast_lane = 1'b0;

    // Goals that land exactly on the wrap, past it, and out of reach.
    send(ModeArmMisc, 5, MsW'(60000 - board.ms));
    send(ModeArmMisc, 6, 16'hFFFF);
    send(ModeArmMain, 0, MsW'(60010 - board.ms));
    send(ModeArmMisc, 7, 200);

    send_random(700);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
